// File: rtl/arq_pkg.sv
// ----------------------------------------------------------------------------
// arq_pkg: shared types and constants for the ack/retry frame sender
// Item, result, state and register types plus register index and request codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arq_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_COMMAND_HEADER    = 3'd0,
        CFG_ACK_HEADER        = 3'd1,
        CFG_ACK_TIMEOUT_TICKS = 3'd2,
        CFG_MAX_ATTEMPTS      = 3'd3,
        CFG_RETRY_GAP_TICKS   = 3'd4
    } arq_cfg_addr_t;

    // Request type codes
    typedef enum logic [1:0] {
        REQ_CMD   = 2'd0,
        REQ_FRAME = 2'd1,
        REQ_TICK  = 2'd2
    } arq_req_t;

    // Send cycle phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_GAP  = 3'b100
    } arq_phase_t;

    localparam logic [7:0]  RST_COMMAND_HEADER    = 8'hAA;
    localparam logic [7:0]  RST_ACK_HEADER        = 8'hBB;
    localparam logic [15:0] RST_ACK_TIMEOUT_TICKS = 16'd2000;
    localparam logic [3:0]  RST_MAX_ATTEMPTS      = 4'd3;
    localparam logic [15:0] RST_RETRY_GAP_TICKS   = 16'd100;

    typedef struct packed {
        logic [7:0]  command_header;
        logic [7:0]  ack_header;
        logic [15:0] ack_timeout_ticks;
        logic [3:0]  max_attempts;
        logic [15:0] retry_gap_ticks;
    } arq_cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  cmd_red;
        logic [7:0]  cmd_green;
        logic [7:0]  cmd_blue;
        logic        cmd_on;
        logic [7:0]  cmd_color_index;
        logic [31:0] rx_frame;
        logic        rx_is_repeat;
    } arq_item_t;

    typedef struct packed {
        logic        tx_send;
        logic [31:0] tx_frame;
        logic        cmd_dropped;
        logic        cycle_done;
        logic        cycle_ok;
        logic        busy_res;
        logic [7:0]  led_red;
        logic [7:0]  led_green;
        logic [7:0]  led_blue;
        logic        light_on;
        logic [7:0]  color_index;
    } arq_result_t;

    typedef struct packed {
        arq_phase_t  phase;
        logic [3:0]  attempt_count;
        logic [15:0] tick_count;
        logic [23:0] pending_rgb;
        logic        pending_on;
        logic [7:0]  pending_index;
        logic [23:0] confirmed_rgb;
        logic        confirmed_on;
        logic [7:0]  confirmed_index;
    } arq_state_t;

endpackage

`default_nettype wire

// File: rtl/arq_cfg.sv
// ----------------------------------------------------------------------------
// arq_cfg: configuration register bank
// Decodes register writes and holds the five sender settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arq_cfg
    import arq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output arq_cfg_t                   cfg
);

    arq_cfg_t cfg_reg;
    arq_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (arq_cfg_addr_t'(cfg_addr))
                CFG_COMMAND_HEADER:    cfg_next.command_header    = cfg_wdata[7:0];
                CFG_ACK_HEADER:        cfg_next.ack_header        = cfg_wdata[7:0];
                CFG_ACK_TIMEOUT_TICKS: cfg_next.ack_timeout_ticks = cfg_wdata;
                CFG_MAX_ATTEMPTS:      cfg_next.max_attempts      = cfg_wdata[3:0];
                CFG_RETRY_GAP_TICKS:   cfg_next.retry_gap_ticks   = cfg_wdata;
                default: ; // drop writes to unmapped indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.command_header    <= RST_COMMAND_HEADER;
            cfg_reg.ack_header        <= RST_ACK_HEADER;
            cfg_reg.ack_timeout_ticks <= RST_ACK_TIMEOUT_TICKS;
            cfg_reg.max_attempts      <= RST_MAX_ATTEMPTS;
            cfg_reg.retry_gap_ticks   <= RST_RETRY_GAP_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/arq_step.sv
// ----------------------------------------------------------------------------
// arq_step: single-item transition logic
// Computes next sender state and the result for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arq_step
    import arq_pkg::*;
(
    input  wire arq_cfg_t   cfg,
    input  wire arq_state_t st,
    input  wire arq_item_t  item,
    output arq_state_t      st_next,
    output arq_result_t     res
);

    logic        busy;
    logic [15:0] tick_inc;
    logic        wait_expired;
    logic        gap_expired;
    logic        ack_match;

    assign busy         = (st.phase == PH_WAIT) || (st.phase == PH_GAP);
    assign tick_inc     = st.tick_count + 16'd1;
    // wrap to zero counts as expiry as well
    assign wait_expired = (tick_inc >= cfg.ack_timeout_ticks) || (tick_inc == 16'd0);
    assign gap_expired  = (tick_inc >= cfg.retry_gap_ticks) || (tick_inc == 16'd0);
    assign ack_match    = !item.rx_is_repeat
                        && (item.rx_frame[31:24] == cfg.ack_header)
                        && (item.rx_frame[23:0] == st.pending_rgb);

    always_comb begin
        st_next = st;
        res     = '0;
        if (!busy) begin
            st_next.phase = PH_IDLE;
        end

        unique case (arq_req_t'(item.req_type))
            REQ_CMD: begin
                if (busy) begin
                    res.cmd_dropped = 1'b1;
                end else begin
                    st_next.pending_rgb   = {item.cmd_red, item.cmd_green, item.cmd_blue};
                    st_next.pending_on    = item.cmd_on;
                    st_next.pending_index = item.cmd_color_index;
                    st_next.attempt_count = 4'd1;
                    st_next.tick_count    = 16'd0;
                    st_next.phase         = PH_WAIT;
                    res.tx_send           = 1'b1;
                end
            end
            REQ_FRAME: begin
                if (st.phase == PH_WAIT && ack_match) begin
                    st_next.confirmed_rgb   = st.pending_rgb;
                    st_next.confirmed_on    = st.pending_on;
                    st_next.confirmed_index = st.pending_index;
                    st_next.phase           = PH_IDLE;
                    st_next.tick_count      = 16'd0;
                    res.cycle_done          = 1'b1;
                    res.cycle_ok            = 1'b1;
                end
            end
            REQ_TICK: begin
                unique case (st.phase)
                    PH_WAIT: begin
                        st_next.tick_count = tick_inc;
                        if (wait_expired) begin
                            st_next.tick_count = 16'd0;
                            if (st.attempt_count >= cfg.max_attempts) begin
                                st_next.phase  = PH_IDLE;
                                res.cycle_done = 1'b1;
                            end else if (cfg.retry_gap_ticks == 16'd0) begin
                                st_next.attempt_count = st.attempt_count + 4'd1;
                                res.tx_send           = 1'b1;
                            end else begin
                                st_next.phase = PH_GAP;
                            end
                        end
                    end
                    PH_GAP: begin
                        st_next.tick_count = tick_inc;
                        if (gap_expired) begin
                            st_next.tick_count    = 16'd0;
                            st_next.attempt_count = st.attempt_count + 4'd1;
                            st_next.phase         = PH_WAIT;
                            res.tx_send           = 1'b1;
                        end
                    end
                    default: ; // idle: ignore ticks
                endcase
            end
            default: ; // unused request code: report status only
        endcase

        if (res.tx_send) begin
            res.tx_frame = {cfg.command_header, st_next.pending_rgb};
        end
        res.busy_res    = (st_next.phase == PH_WAIT) || (st_next.phase == PH_GAP);
        res.led_red     = st_next.confirmed_rgb[23:16];
        res.led_green   = st_next.confirmed_rgb[15:8];
        res.led_blue    = st_next.confirmed_rgb[7:0];
        res.light_on    = st_next.confirmed_on;
        res.color_index = st_next.confirmed_index;
    end

endmodule

`default_nettype wire

// File: rtl/ack_retry_frame_sender.sv
// ----------------------------------------------------------------------------
// ack_retry_frame_sender: stop-and-wait color frame sender with retries
// Requests pass the input register, then the result register; 1 request per cycle while the result side keeps up.
// Rate is set by the combinational step logic between input and result registers.
// Synchronous active-low reset: idle phase, zero counters/colors, default regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ack_retry_frame_sender
    import arq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    // request channel
    input  wire logic                  s_valid,
    output wire logic                  s_ready,
    input  wire logic [1:0]            s_req_type,
    input  wire logic [7:0]            s_cmd_red,
    input  wire logic [7:0]            s_cmd_green,
    input  wire logic [7:0]            s_cmd_blue,
    input  wire logic                  s_cmd_on,
    input  wire logic [7:0]            s_cmd_color_index,
    input  wire logic [31:0]           s_rx_frame,
    input  wire logic                  s_rx_is_repeat,

    // result channel
    output wire logic                  m_valid,
    input  wire logic                  m_ready,
    output wire logic                  m_tx_send,
    output wire logic [31:0]           m_tx_frame,
    output wire logic                  m_cmd_dropped,
    output wire logic                  m_cycle_done,
    output wire logic                  m_cycle_ok,
    output wire logic                  m_busy_res,
    output wire logic [7:0]            m_led_red,
    output wire logic [7:0]            m_led_green,
    output wire logic [7:0]            m_led_blue,
    output wire logic                  m_light_on,
    output wire logic [7:0]            m_color_index
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    arq_cfg_t cfg;

    arq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Input register: capture one request per cycle. It empties whenever
    // the result register can take a new entry, so a request can enter
    // every cycle while the result side keeps up.
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    arq_item_t   in_item_reg;
    logic        out_valid_reg;
    arq_result_t out_res_reg;
    logic        advance;

    // Move the held request into the result register when that register is
    // empty or is being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload: load on accept only, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.req_type        <= s_req_type;
            in_item_reg.cmd_red         <= s_cmd_red;
            in_item_reg.cmd_green       <= s_cmd_green;
            in_item_reg.cmd_blue        <= s_cmd_blue;
            in_item_reg.cmd_on          <= s_cmd_on;
            in_item_reg.cmd_color_index <= s_cmd_color_index;
            in_item_reg.rx_frame        <= s_rx_frame;
            in_item_reg.rx_is_repeat    <= s_rx_is_repeat;
        end
    end

    // ------------------------------------------------------------------
    // Sender state and step logic. State commits only when the request
    // advances, so each request is applied exactly once.
    // ------------------------------------------------------------------
    arq_state_t  state_reg;
    arq_state_t  state_next;
    arq_result_t step_res;

    arq_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .item    (in_item_reg),
        .st_next (state_next),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase           <= PH_IDLE;
            state_reg.attempt_count   <= 4'd0;
            state_reg.tick_count      <= 16'd0;
            state_reg.pending_rgb     <= 24'd0;
            state_reg.pending_on      <= 1'b0;
            state_reg.pending_index   <= 8'd0;
            state_reg.confirmed_rgb   <= 24'd0;
            state_reg.confirmed_on    <= 1'b0;
            state_reg.confirmed_index <= 8'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: holds a finished result until the consumer takes
    // it, while the input register already takes the next request.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_tx_send     = out_res_reg.tx_send;
    assign m_tx_frame    = out_res_reg.tx_frame;
    assign m_cmd_dropped = out_res_reg.cmd_dropped;
    assign m_cycle_done  = out_res_reg.cycle_done;
    assign m_cycle_ok    = out_res_reg.cycle_ok;
    assign m_busy_res    = out_res_reg.busy_res;
    assign m_led_red     = out_res_reg.led_red;
    assign m_led_green   = out_res_reg.led_green;
    assign m_led_blue    = out_res_reg.led_blue;
    assign m_light_on    = out_res_reg.light_on;
    assign m_color_index = out_res_reg.color_index;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A command that reaches a busy sender must come out flagged as dropped.
    a_busy_cmd_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_item_reg.req_type == REQ_CMD)
            && ((state_reg.phase == PH_WAIT) || (state_reg.phase == PH_GAP))
        |=> m_valid && m_cmd_dropped && !m_tx_send)
        else $error("busy command not reported as dropped");

    // A finished cycle leaves the sender idle.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_res.cycle_done |=> !m_busy_res && (state_reg.phase == PH_IDLE))
        else $error("cycle finished but sender still busy");

    // Input side stalls only when both registers are full and output is held.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("request side stalled without a full pipeline");

    // State does not move without a request advancing.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("sender state changed without a request");

endmodule

`default_nettype wire
